// ===== src/ap2d_pkg.sv =====
// ----------------------------------------------------------------------------
// ap2d_pkg
// Shared types, constants and helpers for the 2-D average pooling block.
// ----------------------------------------------------------------------------
package ap2d_pkg;

   // Pixel store geometry
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // Fixed field widths
   localparam int CFG_W   = 7;
   localparam int PAD_W   = 6;
   localparam int IDX_W   = 3;
   localparam int COORD_W = 6;
   localparam int PIX_W   = 16;

   // Window coordinate width: holds 0..MAX and any 7-bit register value
   localparam int DIM_RAW = ($clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1)) ?
                            $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);
   localparam int DIM_W   = (DIM_RAW > CFG_W) ? DIM_RAW : CFG_W;

   // Output position times stride, then signed window origin
   localparam int PROD_W = COORD_W + CFG_W;
   localparam int POS_W  = PROD_W + 2;

   // Window area, sum and divider sizes
   localparam int AREA_W = 2 * DIM_W;
   localparam int SUM_W  = PIX_W + $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(SUM_W);

   // Item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_POOL  = 1'b1;

   // Status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
   localparam logic [IDX_W-1:0] REG_STEP_ROWS    = 3'd2;
   localparam logic [IDX_W-1:0] REG_STEP_COLS    = 3'd3;
   localparam logic [IDX_W-1:0] REG_KERNEL_ROWS  = 3'd4;
   localparam logic [IDX_W-1:0] REG_KERNEL_COLS  = 3'd5;
   localparam logic [IDX_W-1:0] REG_TOP_PADDING  = 3'd6;
   localparam logic [IDX_W-1:0] REG_LEFT_PADDING = 3'd7;

   typedef struct packed {
      logic [CFG_W-1:0] image_height;
      logic [CFG_W-1:0] image_width;
      logic [CFG_W-1:0] step_rows;
      logic [CFG_W-1:0] step_cols;
      logic [CFG_W-1:0] kernel_rows;
      logic [CFG_W-1:0] kernel_cols;
      logic [PAD_W-1:0] top_padding;
      logic [PAD_W-1:0] left_padding;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CLIP,
      ST_CHECK,
      ST_READ,
      ST_DRAIN,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic store;
      logic load_req;
      logic mul;
      logic clip;
      logic start_read;
      logic read;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic empty;
      logic last_pixel;
      logic div_last;
   } stat_type;

   // Clamp a signed window edge into 0..hi
   function automatic logic [DIM_W-1:0] clip_edge(input logic signed [POS_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic signed [POS_W-1:0] hi_s;
      hi_s = $signed(POS_W'(hi));
      if (v < 0)
         clip_edge = '0;
      else if (v > hi_s)
         clip_edge = hi;
      else
         clip_edge = DIM_W'(v);
   endfunction

endpackage

// ===== src/average_pool_2d.sv =====
// ----------------------------------------------------------------------------
// average_pool_2d
// 2-D average pooling over one stored image plane, padding not counted.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: kind 0 stores req_pixel_value at (req_row, req_col);
//    kind 1 asks for the pooled output at output position (req_row, req_col).
//  - rsp_ channel: one transfer per pool request, none per pixel write.
//    rsp_status is 1 when the clipped window covers no pixel (average 0).
//  - csr_ port: csr_we writes csr_wdata to register csr_index at once.
//    Write only while the block is idle.
//  - A pixel write completes when accepted; req_ready stays high for the next item.
//  - A pool request passes from acceptance to rsp_valid through bounds
//    setup, one store read per pixel of the clipped window (single read
//    port), then a 28-step serial divide. An empty window skips the reads
//    and the divide. One request is in flight at a time.
//  - The result sits in an output register, so a stalled receiver does not
//    block acceptance of the next item; the block only waits at the end of
//    a request if the previous result has still not been taken.
//  - Reset (synchronous) returns the controller to idle, drops any pending
//    result and restores register defaults (64x64 image, unit stride and
//    kernel, no padding). The pixel store is not cleared.
// ----------------------------------------------------------------------------
module average_pool_2d (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [ap2d_pkg::COORD_W-1:0]      req_row,
   input  logic [ap2d_pkg::COORD_W-1:0]      req_col,
   input  logic signed [ap2d_pkg::PIX_W-1:0] req_pixel_value,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ap2d_pkg::PIX_W-1:0] rsp_average,
   output logic                              rsp_status,
   // register writes
   input  logic                              csr_we,
   input  logic [ap2d_pkg::IDX_W-1:0]        csr_index,
   input  logic [ap2d_pkg::CFG_W-1:0]        csr_wdata
);
   import ap2d_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   cmd_type  cmd;
   stat_type stat;

   // register file; pads take the low bits of the write data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata;
            REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata;
            REG_STEP_ROWS:    cfg_in.step_rows    = csr_wdata;
            REG_STEP_COLS:    cfg_in.step_cols    = csr_wdata;
            REG_KERNEL_ROWS:  cfg_in.kernel_rows  = csr_wdata;
            REG_KERNEL_COLS:  cfg_in.kernel_cols  = csr_wdata;
            REG_TOP_PADDING:  cfg_in.top_padding  = csr_wdata[PAD_W-1:0];
            REG_LEFT_PADDING: cfg_in.left_padding = csr_wdata[PAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_height <= CFG_W'(64);
         cfg_ff.image_width  <= CFG_W'(64);
         cfg_ff.step_rows    <= CFG_W'(1);
         cfg_ff.step_cols    <= CFG_W'(1);
         cfg_ff.kernel_rows  <= CFG_W'(1);
         cfg_ff.kernel_cols  <= CFG_W'(1);
         cfg_ff.top_padding  <= '0;
         cfg_ff.left_padding <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   ap2d_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_kind (req_kind),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // store, window math, accumulate and divide
   ap2d_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .stat           (stat),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_pixel_value(req_pixel_value),
      .rsp_average    (rsp_average),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== src/ap2d_ram.sv =====
// ----------------------------------------------------------------------------
// ap2d_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ap2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ap2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// ap2d_ctrl
// Sequencer for one pooling request plus the result valid flag.
// ----------------------------------------------------------------------------
module ap2d_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_kind,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ap2d_pkg::stat_type stat,
   output ap2d_pkg::cmd_type  cmd
);
   import ap2d_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_kind == KIND_POOL) state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_CLIP;
         ST_CLIP:  state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = stat.empty ? ST_FINISH : ST_READ;
         end
         ST_READ: begin
            if (stat.last_pixel) state_in = ST_DRAIN;
         end
         ST_DRAIN:    state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            if (stat.div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs; req_ready is high throughout idle, so valid alone marks a transfer
   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.store    = req_valid && req_kind == KIND_WRITE;
            cmd.load_req = req_valid && req_kind == KIND_POOL;
         end
         ST_MUL:      cmd.mul        = 1'b1;
         ST_CLIP:     cmd.clip       = 1'b1;
         ST_CHECK:    cmd.start_read = !stat.empty;
         ST_READ:     cmd.read       = 1'b1;
         ST_DIV_INIT: cmd.div_init   = 1'b1;
         ST_DIV:      cmd.div_step   = 1'b1;
         ST_FINISH:   cmd.out_load   = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // an accepted pool request starts the window setup next cycle
   a_pool_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_POOL) |=> state_ff == ST_MUL)
      else $error("pool request did not start");

   // a new result only appears out of the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   // the divider only runs on a window that covers pixels
   a_div_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !stat.empty)
      else $error("divider running on empty window");

endmodule

// ===== src/ap2d_dp.sv =====
// ----------------------------------------------------------------------------
// ap2d_dp
// Window bounds, pixel store, accumulator, serial divider and result register.
// ----------------------------------------------------------------------------
module ap2d_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  ap2d_pkg::cfg_type                cfg,
   input  ap2d_pkg::cmd_type                cmd,
   output ap2d_pkg::stat_type               stat,
   input  logic [ap2d_pkg::COORD_W-1:0]     req_row,
   input  logic [ap2d_pkg::COORD_W-1:0]     req_col,
   input  logic signed [ap2d_pkg::PIX_W-1:0] req_pixel_value,
   output logic signed [ap2d_pkg::PIX_W-1:0] rsp_average,
   output logic                             rsp_status
);
   import ap2d_pkg::*;

   logic [COORD_W-1:0] row_ff, col_ff;
   logic [PROD_W-1:0]  rprod_ff, cprod_ff;
   logic [DIM_W-1:0]   rs_ff, re_ff, cs_ff, ce_ff;
   logic [DIM_W-1:0]   i_ff, j_ff;
   logic [AREA_W-1:0]  area_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic               acc_valid_ff;
   logic [SUM_W-1:0]   quo_ff;
   logic [AREA_W-1:0]  rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               neg_ff;
   logic signed [PIX_W-1:0] avg_ff;
   logic               status_ff;

   logic [DIM_W-1:0]   h, w;
   logic signed [POS_W-1:0] r0, c0, r1, c1;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic signed [PIX_W-1:0] rd_data;
   logic [AREA_W:0]    rem_sh;
   logic               ge;
   logic [PIX_W-1:0]   qlow;

   // effective image size
   assign h = (DIM_W'(cfg.image_height) > DIM_W'(MAX_ROWS)) ?
              DIM_W'(MAX_ROWS) : DIM_W'(cfg.image_height);
   assign w = (DIM_W'(cfg.image_width) > DIM_W'(MAX_COLS)) ?
              DIM_W'(MAX_COLS) : DIM_W'(cfg.image_width);

   // pixel writes, dropped outside the image
   assign wr_en   = cmd.store && (DIM_W'(req_row) < h) && (DIM_W'(req_col) < w);
   assign wr_addr = ADDR_W'(req_row) * ADDR_W'(MAX_COLS) + ADDR_W'(req_col);
   assign rd_addr = ADDR_W'(i_ff) * ADDR_W'(MAX_COLS) + ADDR_W'(j_ff);

   ap2d_ram #(
      .WIDTH(PIX_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_pixel_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // window origin and far edge, signed
   assign r0 = $signed(POS_W'(rprod_ff)) - $signed(POS_W'(cfg.top_padding));
   assign c0 = $signed(POS_W'(cprod_ff)) - $signed(POS_W'(cfg.left_padding));
   assign r1 = r0 + $signed(POS_W'(cfg.kernel_rows));
   assign c1 = c0 + $signed(POS_W'(cfg.kernel_cols));

   // restoring divide step on magnitude
   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign ge     = rem_sh >= {1'b0, area_ff};
   assign qlow   = quo_ff[PIX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (cmd.mul) begin
         rprod_ff <= PROD_W'(row_ff) * PROD_W'(cfg.step_rows);
         cprod_ff <= PROD_W'(col_ff) * PROD_W'(cfg.step_cols);
      end
      if (cmd.clip) begin
         rs_ff <= clip_edge(r0, h);
         re_ff <= clip_edge(r1, h);
         cs_ff <= clip_edge(c0, w);
         ce_ff <= clip_edge(c1, w);
      end
      if (cmd.start_read) begin
         i_ff    <= rs_ff;
         j_ff    <= cs_ff;
         area_ff <= AREA_W'(re_ff - rs_ff) * AREA_W'(ce_ff - cs_ff);
      end else if (cmd.read) begin
         if (j_ff == ce_ff - DIM_W'(1)) begin
            j_ff <= cs_ff;
            i_ff <= i_ff + DIM_W'(1);
         end else begin
            j_ff <= j_ff + DIM_W'(1);
         end
      end
      // read data lands in the cycle after its address
      if (cmd.start_read) begin
         sum_ff <= '0;
      end else if (acc_valid_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_data);
      end
      if (cmd.div_init) begin
         quo_ff <= sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         neg_ff <= sum_ff[SUM_W-1];
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? AREA_W'(rem_sh - {1'b0, area_ff}) : AREA_W'(rem_sh);
         quo_ff <= {quo_ff[SUM_W-2:0], ge};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.out_load) begin
         if (stat.empty) begin
            avg_ff    <= '0;
            status_ff <= STATUS_EMPTY;
         end else begin
            avg_ff    <= neg_ff ? $signed(-qlow) : $signed(qlow);
            status_ff <= STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= cmd.read;
      end
   end

   assign stat.empty      = (re_ff <= rs_ff) || (ce_ff <= cs_ff);
   assign stat.last_pixel = (i_ff == re_ff - DIM_W'(1)) && (j_ff == ce_ff - DIM_W'(1));
   assign stat.div_last   = cnt_ff == CNT_W'(SUM_W - 1);

   assign rsp_average = avg_ff;
   assign rsp_status  = status_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for average_pool_2d. A scoreboard keeps a private
// copy of the pixel plane and the registers and works out every pooled
// output as the requests go in. Each result is checked against the oldest
// pending pool request. Directed corner cases run first, then random phases
// with both small and extreme register settings under varied flow control.
// ----------------------------------------------------------------------------
module tb;
   import ap2d_pkg::*;

   localparam int COORD_MAX      = (1 << COORD_W) - 1;
   localparam int TOTAL_ITEMS    = 1550;   // input transfers, back-fill included
   localparam int BACKFILL_LIMIT = 48;     // skip pools needing more fresh pixels
   localparam int CFG_TAIL       = 8;      // a pixel write finishes when accepted
   localparam int END_TAIL       = 64;
   localparam int STALL_LIMIT    = 20000;  // > full 64x64 window + divide + stalls

   // One pooled output as predicted for a pool request
   typedef struct {
      logic [COORD_W-1:0]      row;
      logic [COORD_W-1:0]      col;
      logic signed [PIX_W-1:0] average;
      logic                    status;
   } pool_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow registers and pixel plane, queue of pending outputs
   // -------------------------------------------------------------------------
   class pool_scoreboard;
      cfg_type           cfg;
      logic [PIX_W-1:0]  pixels [STORE_DEPTH];
      pool_result_type   expected_pools [$];
      int                errors;

      function new();
         cfg.image_height = 7'd64;
         cfg.image_width  = 7'd64;
         cfg.step_rows    = 7'd1;
         cfg.step_cols    = 7'd1;
         cfg.kernel_rows  = 7'd1;
         cfg.kernel_cols  = 7'd1;
         cfg.top_padding  = '0;
         cfg.left_padding = '0;
         errors = 0;
         foreach (pixels[i]) pixels[i] = '0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            REG_IMAGE_HEIGHT: cfg.image_height = val;
            REG_IMAGE_WIDTH:  cfg.image_width  = val;
            REG_STEP_ROWS:    cfg.step_rows    = val;
            REG_STEP_COLS:    cfg.step_cols    = val;
            REG_KERNEL_ROWS:  cfg.kernel_rows  = val;
            REG_KERNEL_COLS:  cfg.kernel_cols  = val;
            REG_TOP_PADDING:  cfg.top_padding  = val[PAD_W-1:0];
            REG_LEFT_PADDING: cfg.left_padding = val[PAD_W-1:0];
            default: ;
         endcase
      endfunction

      // oversized dimensions act as the store size
      function int image_rows();
         return (cfg.image_height > MAX_ROWS) ? MAX_ROWS : int'(cfg.image_height);
      endfunction

      function int image_cols();
         return (cfg.image_width > MAX_COLS) ? MAX_COLS : int'(cfg.image_width);
      endfunction

      function bit inside_image(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
         return (int'(row) < image_rows()) && (int'(col) < image_cols());
      endfunction

      static function int clamp_to(int v, int hi);
         if (v < 0) return 0;
         if (v > hi) return hi;
         return v;
      endfunction

      // clipped window [rs,re) x [cs,ce) for output position (row, col)
      function void window_of(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                              output int rs, output int re, output int cs, output int ce);
         int r0, c0;
         r0 = int'(row) * int'(cfg.step_rows) - int'(cfg.top_padding);
         c0 = int'(col) * int'(cfg.step_cols) - int'(cfg.left_padding);
         rs = clamp_to(r0, image_rows());
         re = clamp_to(r0 + int'(cfg.kernel_rows), image_rows());
         cs = clamp_to(c0, image_cols());
         ce = clamp_to(c0 + int'(cfg.kernel_cols), image_cols());
      endfunction

      // sum first, then one signed divide (truncates toward zero)
      function pool_result_type pooled_value(logic [COORD_W-1:0] row,
                                             logic [COORD_W-1:0] col);
         pool_result_type res;
         int rs, re, cs, ce;
         longint total;
         res.row     = row;
         res.col     = col;
         res.average = '0;
         res.status  = STATUS_EMPTY;
         window_of(row, col, rs, re, cs, ce);
         if (re > rs && ce > cs) begin
            total = 0;
            for (int i = rs; i < re; i++)
               for (int j = cs; j < ce; j++)
                  total += longint'($signed(pixels[i * MAX_COLS + j]));
            res.average = PIX_W'(total / longint'((re - rs) * (ce - cs)));
            res.status  = STATUS_OK;
         end
         return res;
      endfunction

      function void note_input(logic kind, logic [COORD_W-1:0] row,
                               logic [COORD_W-1:0] col, logic [PIX_W-1:0] value);
         if (kind == KIND_WRITE) begin
            if (inside_image(row, col))
               pixels[int'(row) * MAX_COLS + int'(col)] = value;
         end else begin
            expected_pools.push_back(pooled_value(row, col));
         end
      endfunction

      function void check_result(logic signed [PIX_W-1:0] average, logic status);
         pool_result_type exp;
         if (expected_pools.size() == 0) begin
            $display("%0t: unexpected result, got average %0d status %0d",
                     $time, average, status);
            errors++;
            return;
         end
         exp = expected_pools.pop_front();
         if (status !== exp.status) begin
            $display("%0t: status mismatch at (%0d,%0d), expected %0d, got %0d",
                     $time, exp.row, exp.col, exp.status, status);
            errors++;
         end
         if (average !== exp.average) begin
            $display("%0t: average mismatch at (%0d,%0d), expected %0d, got %0d",
                     $time, exp.row, exp.col, exp.average, average);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                     clock;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_ready;
   logic                     req_kind        = KIND_WRITE;
   logic [COORD_W-1:0]       req_row         = '0;
   logic [COORD_W-1:0]       req_col         = '0;
   logic signed [PIX_W-1:0]  req_pixel_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready       = 1'b0;
   logic signed [PIX_W-1:0]  rsp_average;
   logic                     rsp_status;
   logic                     csr_we          = 1'b0;
   logic [IDX_W-1:0]         csr_index       = '0;
   logic [CFG_W-1:0]         csr_wdata       = '0;

   pool_scoreboard sb;
   bit             pixel_set [STORE_DEPTH];  // store entries written so far
   int             gap_pct   = 0;            // sender idle chance per cycle
   int             stall_pct = 0;            // receiver stall chance per cycle
   int             quiet_cycles = 0;
   int             sent_items   = 0;         // input transfers so far

   average_pool_2d u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_average     (rsp_average),
      .rsp_status      (rsp_status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random back-pressure, one decision per cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor and watchdog. Sampling at the edge sees pre-edge values, since
   // both the bench and the DUT update with nonblocking assignments.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            sb.note_input(req_kind, req_row, req_col, req_pixel_value);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_average, rsp_status);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // One input transfer. Valid stays up across back-to-back items; it only
   // drops when the sender decides to idle before the next one.
   task automatic send_item(logic kind, logic [COORD_W-1:0] row,
                            logic [COORD_W-1:0] col, logic [PIX_W-1:0] value);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_row         <= row;
      req_col         <= col;
      req_pixel_value <= value;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      if (kind == KIND_WRITE && sb.inside_image(row, col))
         pixel_set[int'(row) * MAX_COLS + int'(col)] = 1'b1;
   endtask

   // Pool request; first back-fills any pixel of the clipped window that was
   // never written, so the block never reads an undefined store entry.
   // Requests that would need a large back-fill are skipped.
   task automatic send_pool(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      int rs, re, cs, ce;
      int missing;
      sb.window_of(row, col, rs, re, cs, ce);
      missing = 0;
      for (int i = rs; i < re; i++)
         for (int j = cs; j < ce; j++)
            if (!pixel_set[i * MAX_COLS + j])
               missing++;
      if (missing > BACKFILL_LIMIT) return;
      for (int i = rs; i < re; i++)
         for (int j = cs; j < ce; j++)
            if (!pixel_set[i * MAX_COLS + j])
               send_item(KIND_WRITE, COORD_W'(i), COORD_W'(j), PIX_W'($urandom));
      send_item(KIND_POOL, row, col, PIX_W'($urandom));
   endtask

   // Stop sending, wait until every pool result is back, then let the block
   // run out. The first edge lets the monitor record the last transfer.
   task automatic settle(int tail);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_pools.size() != 0);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   // Registers change only with the block idle
   task automatic apply_config(logic [CFG_W-1:0] height, logic [CFG_W-1:0] width,
                               logic [CFG_W-1:0] srow, logic [CFG_W-1:0] scol,
                               logic [CFG_W-1:0] krow, logic [CFG_W-1:0] kcol,
                               logic [CFG_W-1:0] tpad, logic [CFG_W-1:0] lpad);
      settle(CFG_TAIL);
      write_reg(REG_IMAGE_HEIGHT, height);
      write_reg(REG_IMAGE_WIDTH,  width);
      write_reg(REG_STEP_ROWS,    srow);
      write_reg(REG_STEP_COLS,    scol);
      write_reg(REG_KERNEL_ROWS,  krow);
      write_reg(REG_KERNEL_COLS,  kcol);
      write_reg(REG_TOP_PADDING,  tpad);
      write_reg(REG_LEFT_PADDING, lpad);
      csr_we <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Last output index whose window still starts inside the image
   function automatic int last_useful(int span, int pad, int step);
      int v;
      if (step == 0) return COORD_MAX;
      v = (span - 1 + pad) / step;
      return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   // Mostly within limit, sometimes anywhere (out of image / empty windows)
   function automatic logic [COORD_W-1:0] pick_coord(int limit);
      if (limit < 0 || $urandom_range(99) < 15)
         return COORD_W'($urandom_range(COORD_MAX, 0));
      return COORD_W'($urandom_range(limit, 0));
   endfunction

   function automatic logic [CFG_W-1:0] extreme_value();
      case ($urandom_range(6))
         0:       return 7'd0;
         1:       return 7'd1;
         2:       return 7'd63;
         3:       return 7'd64;
         4:       return 7'd127;
         default: return CFG_W'($urandom_range(127));
      endcase
   endfunction

   // no idling / sender idle / receiver stalls / both
   task automatic set_idle_mode(int mode);
      case (mode)
         0:       begin gap_pct = 0;  stall_pct = 0;  end
         1:       begin gap_pct = 62; stall_pct = 0;  end
         2:       begin gap_pct = 0;  stall_pct = 62; end
         default: begin gap_pct = 37; stall_pct = 37; end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Directed corner cases
   // -------------------------------------------------------------------------
   task automatic run_directed();
      // reset registers: 64x64 plane, 1x1 window -> pool returns the pixel
      send_item(KIND_WRITE, 0, 0, 16'h8000);
      send_item(KIND_WRITE, 63, 63, 16'h7FFF);
      send_item(KIND_WRITE, 0, 5, 16'h1234);
      send_pool(0, 0);
      send_pool(63, 63);

      // SAME-style 3x3 / stride 2 over a 3x3 plane; last window lies past it.
      // The write at (0,5) is outside the plane and must be dropped.
      apply_config(3, 3, 2, 2, 3, 3, 1, 1);
      send_item(KIND_WRITE, 0, 5, 16'hBEEF);
      send_pool(0, 0);
      send_pool(1, 1);
      send_pool(2, 2);

      // oversized dims, zero stride, 64x64 kernel and largest padding:
      // every output lands on the same clipped corner window
      apply_config(127, 100, 0, 0, 64, 64, 63, 63);
      send_pool(17, 42);
      send_pool(63, 0);

      // stride 64 pushes output 1 completely past the image
      apply_config(64, 64, 64, 64, 1, 1, 0, 0);
      send_pool(1, 1);
      send_pool(0, 0);

      // (0,5) must still hold the value written before the dropped write
      apply_config(127, 100, 1, 1, 1, 1, 0, 0);
      send_pool(0, 5);

      // zero image height and zero kernel rows both give an empty window
      apply_config(0, 8, 1, 1, 2, 2, 0, 0);
      send_pool(0, 0);
      apply_config(8, 8, 1, 1, 0, 3, 0, 0);
      send_pool(1, 1);

      // negative average truncates toward zero: (-1 + 0) / 2 -> 0;
      // (7,7) clips a 1x2 window to a single pixel
      apply_config(8, 8, 1, 1, 1, 2, 0, 0);
      send_item(KIND_WRITE, 4, 4, 16'hFFFF);
      send_item(KIND_WRITE, 4, 5, 16'h0000);
      send_pool(4, 4);
      send_pool(7, 7);
   endtask

   // -------------------------------------------------------------------------
   // Random phases: mostly small planes and windows, every fifth phase uses
   // extreme register values with few items to keep big windows cheap
   // -------------------------------------------------------------------------
   task automatic run_random();
      int phase, count;
      bit wide;
      logic [CFG_W-1:0] krow, kcol;
      phase = 0;
      while (sent_items < TOTAL_ITEMS) begin
         wide = (phase % 5 == 4);
         if (wide) begin
            apply_config(extreme_value(), extreme_value(), extreme_value(), extreme_value(),
                         extreme_value(), extreme_value(), extreme_value(), extreme_value());
         end else begin
            krow = CFG_W'($urandom_range(5, 1));
            kcol = CFG_W'($urandom_range(5, 1));
            apply_config(CFG_W'($urandom_range(16, 1)), CFG_W'($urandom_range(16, 1)),
                         CFG_W'($urandom_range(3, 1)), CFG_W'($urandom_range(3, 1)),
                         krow, kcol,
                         CFG_W'($urandom_range(krow, 0)), CFG_W'($urandom_range(kcol, 0)));
         end
         set_idle_mode(phase % 4);
         count = wide ? 12 : 60;
         for (int k = 0; k < count && sent_items < TOTAL_ITEMS; k++) begin
            if ($urandom_range(99) < 35) begin
               send_item(KIND_WRITE, pick_coord(sb.image_rows() - 1),
                         pick_coord(sb.image_cols() - 1), PIX_W'($urandom));
            end else begin
               send_pool(pick_coord(last_useful(sb.image_rows(), int'(sb.cfg.top_padding),
                                                int'(sb.cfg.step_rows))),
                         pick_coord(last_useful(sb.image_cols(), int'(sb.cfg.left_padding),
                                                int'(sb.cfg.step_cols))));
            end
         end
         phase++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      settle(END_TAIL);
      if (sb.errors == 0 && sb.expected_pools.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (sb.expected_pools.size() != 0)
            $display("%0t: %0d pool results never arrived", $time,
                     sb.expected_pools.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
